>>> hdl/klt_pkg.sv
`timescale 1ns / 1ps

package klt_pkg;

    localparam int POS_BITS_DEF     = 16;
    localparam int VALUE_BITS_DEF   = 32;
    localparam int PREFIX_CHARS_DEF = 7;

    localparam int KIND_W      = 5;
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [KIND_W-1:0] K_ID     = 5'd0;
    localparam logic [KIND_W-1:0] K_NUMBER = 5'd1;
    localparam logic [KIND_W-1:0] K_KW0    = 5'd2;
    localparam logic [KIND_W-1:0] K_ASSIGN = 5'd12;
    localparam logic [KIND_W-1:0] K_EQ     = 5'd13;
    localparam logic [KIND_W-1:0] K_PUNCT0 = 5'd14;
    localparam logic [KIND_W-1:0] K_END    = 5'd26;
    localparam logic [KIND_W-1:0] K_ERROR  = 5'd27;

    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam int NUM_KW = 10;
    localparam int KW_MAX = 7;

    localparam int KW_LEN [NUM_KW] = '{7, 3, 4, 2, 4, 5, 5, 5, 6, 6};

    localparam logic [7:0] KW_CHARS [NUM_KW][KW_MAX] = '{
        '{"d", "e", "c", "l", "a", "r", "e"},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00, 8'h00},
        '{"c", "l", "a", "s", "s", 8'h00, 8'h00},
        '{"m", "e", "t", "h", "o", "d", 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00}
    };

    localparam int NUM_PUNCT = 12;

    localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
        "+", "-", "*", "/", ".", ",", ":", ";", "(", ")", "{", "}"
    };

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic int bundle_bits(int pos_bits, int value_bits);
        return 2 + MAX_RESULTS * (KIND_W + 2 * pos_bits + value_bits);
    endfunction

endpackage

>>> hdl/keyword_lexer_tokenizer_unit.sv
`timescale 1ns / 1ps
// The first token of a character passes through the token queue and the registered
// output stage before it is valid. One character per cycle while the queue has room;
// a character's two or three tokens leave in turn via a four-entry token-bundle queue.
// Reset: synchronous active low; clears lexer state, position, queue and output valid.

module keyword_lexer_tokenizer_unit
    import klt_pkg::*;
#(
    parameter int POS_BITS     = POS_BITS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF,
    parameter int PREFIX_CHARS = PREFIX_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_ch,
    input  logic                  i_has_char,
    input  logic                  i_end_of_source,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [KIND_W-1:0]     o_kind,
    output logic [POS_BITS-1:0]   o_start_res,
    output logic [POS_BITS-1:0]   o_length,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_last
);

    localparam int BUNDLE_W = bundle_bits(POS_BITS, VALUE_BITS);

    t_q_stat             q_stat;
    logic                q_push;
    logic                q_pop;
    logic [BUNDLE_W-1:0] q_wr_data;
    logic [BUNDLE_W-1:0] q_rd_data;

    klt_front #(
        .POS_BITS     (POS_BITS),
        .VALUE_BITS   (VALUE_BITS),
        .PREFIX_CHARS (PREFIX_CHARS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_ch            (i_ch),
        .i_has_char      (i_has_char),
        .i_end_of_source (i_end_of_source),
        .i_q_stat        (q_stat),
        .o_push          (q_push),
        .o_bundle        (q_wr_data)
    );

    klt_queue #(
        .WIDTH (BUNDLE_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_stat  (q_stat)
    );

    klt_back #(
        .POS_BITS   (POS_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_rd_data),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_start_res (o_start_res),
        .o_length    (o_length),
        .o_value     (o_value),
        .o_last      (o_last)
    );

endmodule

>>> hdl/klt_front.sv
`timescale 1ns / 1ps

module klt_front
    import klt_pkg::*;
#(
    parameter int POS_BITS     = POS_BITS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF,
    parameter int PREFIX_CHARS = PREFIX_CHARS_DEF,
    localparam int BUNDLE_W    = bundle_bits(POS_BITS, VALUE_BITS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_ch,
    input  logic                i_has_char,
    input  logic                i_end_of_source,
    input  t_q_stat             i_q_stat,
    output logic                o_push,
    output logic [BUNDLE_W-1:0] o_bundle
);

    localparam int PIDX_W = $clog2(PREFIX_CHARS);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM
    } t_mode;

    typedef logic [7:0] t_prefix [PREFIX_CHARS];

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [POS_BITS-1:0]   start;
        logic [POS_BITS-1:0]   len;
        logic [VALUE_BITS-1:0] value;
    } t_token;

    typedef struct packed {
        logic [1:0]                    count;
        t_token [MAX_RESULTS-1:0]      tok;
    } t_bundle;

    t_mode                 r_mode, n_mode;
    logic                  r_peq, n_peq;
    t_prefix               r_prefix, n_prefix;
    logic [POS_BITS-1:0]   r_len, n_len;
    logic [POS_BITS-1:0]   r_start, n_start;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_halt, n_halt;

    t_bundle               n_bundle;
    logic                  v_done;
    logic                  v_digit;
    logic                  v_alpha;
    logic                  v_space;
    logic                  v_punct;
    logic [3:0]            v_pidx;
    logic                  accept;

    function automatic t_token f_tok(logic [KIND_W-1:0] kind, logic [POS_BITS-1:0] start,
                                     logic [POS_BITS-1:0] len, logic [VALUE_BITS-1:0] value);
        t_token t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.value = value;
        return t;
    endfunction

    function automatic logic [POS_BITS-1:0] f_inc(logic [POS_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [VALUE_BITS-1:0] f_acc(logic [VALUE_BITS-1:0] acc,
                                                    logic [3:0] d);
        logic [VALUE_BITS+3:0] w;
        logic [VALUE_BITS+3:0] s;
        w = {4'b0000, acc};
        s = (w << 3) + (w << 1) + (VALUE_BITS + 4)'(d);
        return (s[VALUE_BITS+3:VALUE_BITS] != 4'b0000) ? '1 : s[VALUE_BITS-1:0];
    endfunction

    function automatic logic [KIND_W-1:0] f_word_kind(t_prefix p, logic [POS_BITS-1:0] len);
        logic [KIND_W-1:0] kind;
        logic              hit;
        kind = K_ID;
        for (int k = 0; k < NUM_KW; k++) begin
            hit = (len == POS_BITS'(KW_LEN[k]));
            for (int j = 0; j < KW_MAX; j++) begin
                if (j < KW_LEN[k] && p[j] != KW_CHARS[k][j]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = K_KW0 + KIND_W'(k);
            end
        end
        return kind;
    endfunction

    assign accept   = i_valid & ~i_q_stat.full;
    assign o_stall  = i_q_stat.full;
    assign o_push   = accept & (n_bundle.count != 2'd0);
    assign o_bundle = n_bundle;

    always_comb begin
        v_digit = (i_ch >= "0") && (i_ch <= "9");
        v_alpha = ((i_ch >= "a") && (i_ch <= "z")) || ((i_ch >= "A") && (i_ch <= "Z"));
        v_space = (i_ch == " ") || ((i_ch >= 8'd9) && (i_ch <= 8'd13));
        v_punct = 1'b0;
        v_pidx  = '0;
        for (int k = 0; k < NUM_PUNCT; k++) begin
            if (i_ch == PUNCT_CHARS[k]) begin
                v_punct = 1'b1;
                v_pidx  = 4'(k);
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_peq    = r_peq;
        n_prefix = r_prefix;
        n_len    = r_len;
        n_start  = r_start;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_halt   = r_halt;
        n_bundle = '0;
        v_done   = 1'b0;

        if (i_has_char) begin
            if (!r_halt) begin
                if (n_peq) begin
                    if (i_ch == CH_EQUALS) begin
                        n_bundle.tok[n_bundle.count] = f_tok(K_EQ, n_start, POS_BITS'(2), '0);
                        n_bundle.count = n_bundle.count + 2'd1;
                        v_done = 1'b1;
                    end else begin
                        n_bundle.tok[n_bundle.count] = f_tok(K_ASSIGN, n_start, POS_BITS'(1), '0);
                        n_bundle.count = n_bundle.count + 2'd1;
                        n_mode = MODE_IDLE;
                        n_len  = '0;
                        n_acc  = '0;
                    end
                    n_peq = 1'b0;
                end

                if (!v_done && n_mode == MODE_WORD) begin
                    if (v_alpha || v_digit || i_ch == CH_UNDERSCORE) begin
                        if (n_len < POS_BITS'(PREFIX_CHARS)) begin
                            n_prefix[n_len[PIDX_W-1:0]] = i_ch;
                        end
                        n_len  = f_inc(n_len);
                        v_done = 1'b1;
                    end else begin
                        n_bundle.tok[n_bundle.count] =
                            f_tok(f_word_kind(n_prefix, n_len), n_start, n_len, '0);
                        n_bundle.count = n_bundle.count + 2'd1;
                        n_mode = MODE_IDLE;
                        n_len  = '0;
                        n_acc  = '0;
                    end
                end else if (!v_done && n_mode == MODE_NUM) begin
                    if (v_digit) begin
                        n_acc  = f_acc(n_acc, i_ch[3:0]);
                        n_len  = f_inc(n_len);
                        v_done = 1'b1;
                    end else begin
                        n_bundle.tok[n_bundle.count] = f_tok(K_NUMBER, n_start, n_len, n_acc);
                        n_bundle.count = n_bundle.count + 2'd1;
                        n_mode = MODE_IDLE;
                        n_len  = '0;
                        n_acc  = '0;
                    end
                end

                if (!v_done) begin
                    if (v_space) begin
                        n_mode = n_mode;
                    end else if (v_alpha || i_ch == CH_UNDERSCORE) begin
                        n_mode      = MODE_WORD;
                        n_start     = n_pos;
                        n_prefix[0] = i_ch;
                        n_len       = POS_BITS'(1);
                    end else if (v_digit) begin
                        n_mode  = MODE_NUM;
                        n_start = n_pos;
                        n_len   = POS_BITS'(1);
                        n_acc   = VALUE_BITS'(i_ch[3:0]);
                    end else if (i_ch == CH_EQUALS) begin
                        n_peq   = 1'b1;
                        n_start = n_pos;
                    end else if (v_punct) begin
                        n_bundle.tok[n_bundle.count] =
                            f_tok(K_PUNCT0 + KIND_W'(v_pidx), n_pos, POS_BITS'(1), '0);
                        n_bundle.count = n_bundle.count + 2'd1;
                    end else begin
                        n_bundle.tok[n_bundle.count] = f_tok(K_ERROR, n_pos, POS_BITS'(1), '0);
                        n_bundle.count = n_bundle.count + 2'd1;
                        n_halt = 1'b1;
                    end
                end
            end
            n_pos = f_inc(n_pos);
        end

        if (i_end_of_source) begin
            if (!n_halt) begin
                if (n_peq) begin
                    n_bundle.tok[n_bundle.count] = f_tok(K_ASSIGN, n_start, POS_BITS'(1), '0);
                    n_bundle.count = n_bundle.count + 2'd1;
                end else if (n_mode == MODE_WORD) begin
                    n_bundle.tok[n_bundle.count] =
                        f_tok(f_word_kind(n_prefix, n_len), n_start, n_len, '0);
                    n_bundle.count = n_bundle.count + 2'd1;
                end else if (n_mode == MODE_NUM) begin
                    n_bundle.tok[n_bundle.count] = f_tok(K_NUMBER, n_start, n_len, n_acc);
                    n_bundle.count = n_bundle.count + 2'd1;
                end
            end
            n_bundle.tok[n_bundle.count] = f_tok(K_END, n_pos, '0, '0);
            n_bundle.count = n_bundle.count + 2'd1;
            n_mode  = MODE_IDLE;
            n_peq   = 1'b0;
            n_len   = '0;
            n_start = '0;
            n_pos   = '0;
            n_acc   = '0;
            n_halt  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_peq   <= 1'b0;
            r_len   <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_acc   <= '0;
            r_halt  <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_peq   <= n_peq;
            r_len   <= n_len;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prefix <= n_prefix;
        end
    end

endmodule

>>> hdl/klt_queue.sv
`timescale 1ns / 1ps

module klt_queue
    import klt_pkg::*;
#(
    parameter int WIDTH = bundle_bits(POS_BITS_DEF, VALUE_BITS_DEF)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/klt_back.sv
`timescale 1ns / 1ps

module klt_back
    import klt_pkg::*;
#(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int BUNDLE_W  = bundle_bits(POS_BITS, VALUE_BITS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [BUNDLE_W-1:0]   i_q_data,
    input  t_q_stat               i_q_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [KIND_W-1:0]     o_kind,
    output logic [POS_BITS-1:0]   o_start_res,
    output logic [POS_BITS-1:0]   o_length,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_last
);

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [POS_BITS-1:0]   start;
        logic [POS_BITS-1:0]   len;
        logic [VALUE_BITS-1:0] value;
    } t_token;

    typedef struct packed {
        logic [1:0]               count;
        t_token [MAX_RESULTS-1:0] tok;
    } t_bundle;

    t_bundle    head;
    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    t_token     r_tok;
    logic       r_last;
    logic       load;
    logic       at_last;

    assign head    = i_q_data;
    assign load    = ~i_q_stat.empty & (~r_valid | ~i_stall);
    assign at_last = (r_idx == head.count - 2'd1);
    assign o_pop   = load & at_last;
    assign n_idx   = at_last ? 2'd0 : r_idx + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= head.tok[r_idx];
            r_last <= at_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_tok.kind;
    assign o_start_res = r_tok.start;
    assign o_length    = r_tok.len;
    assign o_value     = r_tok.value;
    assign o_last      = r_last;

endmodule

>>> hdl/klt_checker.sv
`timescale 1ns / 1ps

module klt_checker
    import klt_pkg::*;
#(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [KIND_W-1:0]     o_kind,
    input logic [POS_BITS-1:0]   o_length,
    input logic [VALUE_BITS-1:0] o_value,
    input logic                  o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_value))
        else $error("stalled token changed");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_END |-> o_last && o_length == '0)
        else $error("end token not final or nonzero length");

    a_value_only_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_NUMBER |-> o_value == '0)
        else $error("nonzero value on non-number token");

endmodule

bind keyword_lexer_tokenizer_unit klt_checker #(
    .POS_BITS   (POS_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_klt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_kind   (o_kind),
    .o_length (o_length),
    .o_value  (o_value),
    .o_last   (o_last)
);
